[src/pycc_pkg.sv]
// pycc_pkg: coefficients, biases and stage payload types for the palette
// rgba to ycbcr converter; no dependencies
`default_nettype none
package pycc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W = 24;
	localparam int ALPHA_W = 7;

	// bt.709 coefficients folded with the limited-range scale, units of 2^-16
	localparam logic [15:0] Y_KR = 16'd11960;
	localparam logic [15:0] Y_KG = 16'd40265;
	localparam logic [15:0] Y_KB = 16'd4058;
	localparam logic [15:0] C_HALF = 16'd28784;
	localparam logic [15:0] CB_KR = 16'd6620;
	localparam logic [15:0] CB_KG = 16'd22222;
	localparam logic [15:0] CR_KG = 16'd26136;
	localparam logic [15:0] CR_KB = 16'd2648;

	localparam int ROUND_HALF = 32768;
	localparam int Y_OFFSET = 16;
	localparam int C_OFFSET = 128;
	localparam logic [ACC_W-1:0] Y_BIAS = ACC_W'((Y_OFFSET << FRAC_BITS) + ROUND_HALF);
	localparam logic [ACC_W-1:0] C_BIAS = ACC_W'((C_OFFSET << FRAC_BITS) + ROUND_HALF);

	localparam logic [7:0] LEVEL_MIN = 8'd1;
	localparam logic [7:0] LEVEL_MAX = 8'd254;
	localparam logic [7:0] CHROMA_SHIFT = 8'h80;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               last;
		logic [ACC_W-1:0]   y_r;
		logic [ACC_W-1:0]   y_g;
		logic [ACC_W-1:0]   y_b;
		logic [ACC_W-1:0]   cb_r;
		logic [ACC_W-1:0]   cb_g;
		logic [ACC_W-1:0]   cb_b;
		logic [ACC_W-1:0]   cr_r;
		logic [ACC_W-1:0]   cr_g;
		logic [ACC_W-1:0]   cr_b;
	} prod_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               last;
		logic [ACC_W-1:0]   y_acc;
		logic [ACC_W-1:0]   cb_acc;
		logic [ACC_W-1:0]   cr_acc;
	} sum_t;

endpackage
`default_nettype wire

[src/pycc_mul.sv]
// pycc_mul: first stage, nine constant products and the alpha rescale
// depends on pycc_pkg
`default_nettype none
module pycc_mul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [31:0]     rgba_word,
	input  wire logic            last_entry,
	output logic                 valid_s1,
	output pycc_pkg::prod_t      prod_s1
);

	logic [7:0]  a, r, g, b;
	logic [13:0] a64;
	logic [14:0] a_div;
	pycc_pkg::prod_t prod_d;

	assign a = rgba_word[7:0];
	assign r = rgba_word[15:8];
	assign g = rgba_word[23:16];
	assign b = rgba_word[31:24];

	// floor(x/255) as (x + (x>>8) + 1) >> 8, exact for x below 65535
	assign a64 = {a, 6'b0};
	assign a_div = 15'(a64) + 15'(a64 >> 8) + 15'd1;

	always_comb begin
		prod_d.alpha = a_div[14:8];
		prod_d.last  = last_entry;
		prod_d.y_r   = pycc_pkg::ACC_W'(pycc_pkg::Y_KR * 24'(r));
		prod_d.y_g   = pycc_pkg::ACC_W'(pycc_pkg::Y_KG * 24'(g));
		prod_d.y_b   = pycc_pkg::ACC_W'(pycc_pkg::Y_KB * 24'(b));
		prod_d.cb_r  = pycc_pkg::ACC_W'(pycc_pkg::CB_KR * 24'(r));
		prod_d.cb_g  = pycc_pkg::ACC_W'(pycc_pkg::CB_KG * 24'(g));
		prod_d.cb_b  = pycc_pkg::ACC_W'(pycc_pkg::C_HALF * 24'(b));
		prod_d.cr_r  = pycc_pkg::ACC_W'(pycc_pkg::C_HALF * 24'(r));
		prod_d.cr_g  = pycc_pkg::ACC_W'(pycc_pkg::CR_KG * 24'(g));
		prod_d.cr_b  = pycc_pkg::ACC_W'(pycc_pkg::CR_KB * 24'(b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			prod_s1 <= prod_d;
		end
	end

endmodule
`default_nettype wire

[src/pycc_sum.sv]
// pycc_sum: second stage, adds and subtracts products and adds rounding biases per component
// depends on pycc_pkg
`default_nettype none
module pycc_sum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire pycc_pkg::prod_t  prod_s1,
	output logic                  valid_s2,
	output pycc_pkg::sum_t        sum_s2
);

	pycc_pkg::sum_t sum_d;

	// chroma sums stay positive for byte inputs, so unsigned wrap never occurs
	always_comb begin
		sum_d.alpha  = prod_s1.alpha;
		sum_d.last   = prod_s1.last;
		sum_d.y_acc  = prod_s1.y_r + prod_s1.y_g + prod_s1.y_b + pycc_pkg::Y_BIAS;
		sum_d.cb_acc = prod_s1.cb_b + pycc_pkg::C_BIAS - prod_s1.cb_r - prod_s1.cb_g;
		sum_d.cr_acc = prod_s1.cr_r + pycc_pkg::C_BIAS - prod_s1.cr_g - prod_s1.cr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sum_s2 <= sum_d;
		end
	end

endmodule
`default_nettype wire

[src/pycc_pack.sv]
// pycc_pack: third stage, clamps levels, shifts chroma and packs the result
// depends on pycc_pkg
`default_nettype none
module pycc_pack (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s2,
	input  wire pycc_pkg::sum_t  sum_s2,
	output logic                 valid_s3,
	output logic [31:0]          packed_s3,
	output logic [6:0]           alpha_s3,
	output logic [7:0]           luma_s3,
	output logic [7:0]           cr_s3,
	output logic [7:0]           cb_s3,
	output logic                 last_s3
);

	logic [7:0] y_lvl, cr_lvl, cb_lvl, cr_sh, cb_sh;

	function automatic logic [7:0] clamp_level(input logic [7:0] v);
		logic [7:0] res;
		res = v;
		if (v == 8'd0) begin
			res = pycc_pkg::LEVEL_MIN;
		end else if (v == 8'd255) begin
			res = pycc_pkg::LEVEL_MAX;
		end
		return res;
	endfunction

	assign y_lvl  = clamp_level(sum_s2.y_acc[pycc_pkg::FRAC_BITS +: 8]);
	assign cr_lvl = clamp_level(sum_s2.cr_acc[pycc_pkg::FRAC_BITS +: 8]);
	assign cb_lvl = clamp_level(sum_s2.cb_acc[pycc_pkg::FRAC_BITS +: 8]);
	assign cr_sh  = cr_lvl + pycc_pkg::CHROMA_SHIFT;
	assign cb_sh  = cb_lvl + pycc_pkg::CHROMA_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			packed_s3 <= {1'b0, sum_s2.alpha, y_lvl, cr_sh, cb_sh};
			alpha_s3  <= sum_s2.alpha;
			luma_s3   <= y_lvl;
			cr_s3     <= cr_sh;
			cb_s3     <= cb_sh;
			last_s3   <= sum_s2.last;
		end
	end

endmodule
`default_nettype wire

[src/palette_rgba_to_ycbcr.sv]
// palette_rgba_to_ycbcr: top level, three-stage rgba to limited-range ycbcr
// depends on pycc_pkg, pycc_mul, pycc_sum, pycc_pack
//
// One item per clock: busy is always low, so start may be high in every
// cycle. Each item's result passes through the multiply, add and
// clamp/pack register stages in that order, and is on the outputs with
// done high for a single cycle. Results come out in input order and
// cannot be held off, so the receiver must take every done cycle.
`default_nettype none
module palette_rgba_to_ycbcr (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] rgba_word,
	input  wire logic        last_entry,
	output logic             done,
	output logic [31:0]      packed_word,
	output logic [6:0]       alpha_level,
	output logic [7:0]       luma,
	output logic [7:0]       cr_shifted,
	output logic [7:0]       cb_shifted,
	output logic             last_out
);

	logic            valid_s1, valid_s2;
	pycc_pkg::prod_t prod_s1;
	pycc_pkg::sum_t  sum_s2;

	assign busy = 1'b0;

	pycc_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.rgba_word  (rgba_word),
		.last_entry (last_entry),
		.valid_s1   (valid_s1),
		.prod_s1    (prod_s1)
	);

	pycc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2)
	);

	pycc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.sum_s2    (sum_s2),
		.valid_s3  (done),
		.packed_s3 (packed_word),
		.alpha_s3  (alpha_level),
		.luma_s3   (luma),
		.cr_s3     (cr_shifted),
		.cb_s3     (cb_shifted),
		.last_s3   (last_out)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("item did not produce a result three cycles later");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (luma != 8'd0 && luma != 8'd255))
		else $error("luma outside clamped range");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (alpha_level <= 7'd64))
		else $error("alpha level above 64");

	a_packed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (packed_word[23:16] == luma && packed_word[30:24] == alpha_level
			&& packed_word[15:8] == cr_shifted && packed_word[7:0] == cb_shifted))
		else $error("packed word disagrees with separate fields");
`endif

endmodule
`default_nettype wire
